// ----- rtl/assert_macros.svh -----
// Assertion helper macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/sbus_pkg.sv -----
// Shared constants, types and channel unpack function for the S.BUS decoder.
// No dependencies.
package sbus_pkg;

    localparam int WIN_LEN   = 25;
    localparam int NUM_SLOTS = 16;
    localparam int CH_W      = 11;
    localparam int SLOT_W    = 4;
    localparam int FRESH_W   = 5;
    localparam int LOST_W    = 5;
    localparam int FIELD_W   = NUM_SLOTS * CH_W;  // bytes 1..22

    localparam logic [7:0]         SYNC_BYTE  = 8'h0F;
    localparam logic [7:0]         END_BYTE   = 8'h00;
    localparam logic [7:0]         LOST_FLAGS = 8'h0C;
    localparam logic [LOST_W-1:0]  LOST_SAT   = 5'd30;
    localparam logic [LOST_W-1:0]  LIMIT_RST  = 5'd25;
    localparam logic [FRESH_W-1:0] FRESH_FULL = 5'd25;
    localparam logic [FRESH_W-1:0] FRESH_NEAR = 5'd24;
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = 4'd15;

    typedef logic [NUM_SLOTS-1:0][CH_W-1:0] t_chan_arr;

    typedef struct packed {
        logic busy;       // results of a frame still pending
        logic last_xfer;  // final slot transferred this cycle
    } t_emit_stat;

    // channel s of the packed field, slots 1 and 2 swapped
    function automatic t_chan_arr unpack_frame(input logic [FIELD_W-1:0] f);
        t_chan_arr c;
        int        src;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            src  = (s == 1) ? 2 : (s == 2) ? 1 : s;
            c[s] = f[CH_W*src +: CH_W];
        end
        return c;
    endfunction

endpackage

// ----- rtl/sbus_emit.sv -----
// Result sequencer: holds one decoded frame and sends its 16 channels in slot order.
// Depends on sbus_pkg.
module sbus_emit
    import sbus_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_chan_arr            i_chans,
    input  logic                 i_link,
    input  logic                 i_ch_stall,
    output t_emit_stat           o_status,
    output logic                 o_ch_valid,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [CH_W-1:0]      o_value,
    output logic                 o_link_up,
    output logic                 o_last
);

    logic              r_busy;
    logic [SLOT_W-1:0] r_slot;
    t_chan_arr         r_ch;
    logic              r_link;
    logic              xfer;

    assign xfer = r_busy && !i_ch_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_slot <= '0;
        end else if (xfer) begin
            r_slot <= r_slot + 1'b1;
            if (r_slot == LAST_SLOT) begin
                r_busy <= 1'b0;
            end
        end
    end

    // payload: channel queue shifts toward entry 0 on each transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ch   <= i_chans;
            r_link <= i_link;
        end else if (xfer) begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                r_ch[i] <= r_ch[i+1];
            end
        end
    end

    assign o_ch_valid         = r_busy;
    assign o_slot             = r_slot;
    assign o_value            = r_ch[0];
    assign o_link_up          = r_link;
    assign o_last             = (r_slot == LAST_SLOT);
    assign o_status.busy      = r_busy;
    assign o_status.last_xfer = xfer && (r_slot == LAST_SLOT);

endmodule

// ----- rtl/sbus_frame_decoder_top.sv -----
// S.BUS frame decoder: one received byte per transfer, 16 channel results per frame.
// Latency: first result valid the cycle after the frame-closing byte is taken;
// the 16 results follow at one per cycle while the output is not stalled.
// Throughput: one byte per cycle; input stalls only while a frame's results are
// still pending and 24 or more bytes have come in since that frame.
// Reset: synchronous, active low; clears window and counters, sets the limit to 25, no results pending.
module sbus_frame_decoder_top
    import sbus_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_stall,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_we,
    input  logic [LOST_W-1:0]   i_cfg_wdata,
    output logic                o_ch_valid,
    input  logic                i_ch_stall,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [CH_W-1:0]     o_value,
    output logic                o_link_up,
    output logic                o_last
);

`include "assert_macros.svh"

    logic [7:0]         r_win [WIN_LEN];
    logic [FRESH_W-1:0] r_fresh;
    logic [FRESH_W-1:0] n_fresh;
    logic [LOST_W-1:0]  r_lost;
    logic [LOST_W-1:0]  n_lost;
    logic               n_link;
    logic [LOST_W-1:0]  r_lost_limit;
    logic               rx_xfer;
    logic               frame_hit;
    logic [FIELD_W-1:0] field;
    t_chan_arr          chans;
    t_emit_stat         emit_stat;

    // hold off a byte that could close a frame while the last one is still going out
    assign o_rx_stall = emit_stat.busy && (r_fresh >= FRESH_NEAR);
    assign rx_xfer    = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_fresh = (r_fresh < FRESH_FULL) ? r_fresh + 1'b1 : r_fresh;
        // window after shift: new[0] = r_win[1], new[24] = incoming byte
        frame_hit = rx_xfer && (r_win[1] == SYNC_BYTE) && (i_rx_byte == END_BYTE)
                    && (n_fresh == FRESH_FULL);
        for (int k = 1; k <= 22; k++) begin
            field[8*(k-1) +: 8] = r_win[k+1];
        end
        // flags byte lands at new[23] = r_win[24]
        if (r_win[24] == LOST_FLAGS) begin
            n_lost = (r_lost < LOST_SAT) ? r_lost + 1'b1 : r_lost;
        end else begin
            n_lost = '0;
        end
        n_link = (n_lost <= r_lost_limit);
        chans  = unpack_frame(field);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
            r_fresh <= '0;
            r_lost  <= '0;
        end else if (rx_xfer) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_LEN-1] <= i_rx_byte;
            if (frame_hit) begin
                r_fresh <= '0;
                r_lost  <= n_lost;
            end else begin
                r_fresh <= n_fresh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            r_lost_limit <= i_cfg_wdata;
        end
    end

    sbus_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (frame_hit),
        .i_chans    (chans),
        .i_link     (n_link),
        .i_ch_stall (i_ch_stall),
        .o_status   (emit_stat),
        .o_ch_valid (o_ch_valid),
        .o_slot     (o_slot),
        .o_value    (o_value),
        .o_link_up  (o_link_up),
        .o_last     (o_last)
    );

    `AST_IMPL(a_no_load_busy, i_clk, i_rst_n, frame_hit, !emit_stat.busy)
    `AST_NEXT(a_frame_starts, i_clk, i_rst_n, frame_hit, o_ch_valid && (o_slot == '0))
    `AST_NEXT(a_last_ends, i_clk, i_rst_n, emit_stat.last_xfer, !o_ch_valid)
    `AST_IMPL(a_lost_sat, i_clk, i_rst_n, 1'b1, (r_lost <= LOST_SAT) && (r_fresh <= FRESH_FULL))

endmodule

// ----- tb/sv/sbus_frame_checker.sv -----
`timescale 1ns / 1ps
// Checker for the S.BUS frame decoder: tracks byte and channel transfers, predicts channels.
// Depends on sbus_pkg for widths and frame constants.
module sbus_frame_checker
    import sbus_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    input  logic              i_rx_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_we,
    input  logic [LOST_W-1:0] i_cfg_wdata,
    input  logic              i_ch_valid,
    input  logic              i_ch_stall,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [CH_W-1:0]   i_value,
    input  logic              i_link_up,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_frames,
    output int                o_results
);

    localparam int FLAGS_POS = WIN_LEN - 2;
    localparam int DATA_LEN  = WIN_LEN - 3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CH_W-1:0]   value;
        logic              link_up;
        logic              last;
    } t_chan_result;

    t_chan_result      expected_channels[$];
    logic [7:0]        rx_window [WIN_LEN];
    logic [FRESH_W-1:0] bytes_since_frame;
    logic [LOST_W-1:0] missed_frames;
    logic              link_ok;
    logic [LOST_W-1:0] lost_limit;

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_channel();
        t_chan_result want;
        o_results++;
        if (expected_channels.size() == 0) begin
            note_failure($sformatf("unexpected channel slot %0d value %0d", i_slot, i_value));
            return;
        end
        want = expected_channels.pop_front();
        if (want.slot !== i_slot || want.value !== i_value ||
            want.link_up !== i_link_up || want.last !== i_last)
            note_failure($sformatf(
                "slot %0d/%0d value %0d/%0d link %0b/%0b last %0b/%0b (exp/act)",
                want.slot, i_slot, want.value, i_value,
                want.link_up, i_link_up, want.last, i_last));
    endtask

    // shift one byte in; on a frame, queue its 16 channels
    task automatic take_byte(input logic [7:0] b);
        logic [FIELD_W-1:0] data_bits;
        t_chan_result       r;
        int                 src;
        for (int i = 0; i < WIN_LEN - 1; i++)
            rx_window[i] = rx_window[i+1];
        rx_window[WIN_LEN-1] = b;
        if (bytes_since_frame < FRESH_FULL)
            bytes_since_frame++;
        if (rx_window[0] != SYNC_BYTE || rx_window[WIN_LEN-1] != END_BYTE ||
            bytes_since_frame < FRESH_FULL)
            return;
        bytes_since_frame = '0;
        if (rx_window[FLAGS_POS] == LOST_FLAGS) begin
            if (missed_frames < LOST_SAT)
                missed_frames++;
        end else begin
            missed_frames = '0;
        end
        link_ok = (missed_frames <= lost_limit);
        for (int i = 0; i < DATA_LEN; i++)
            data_bits[8*i +: 8] = rx_window[i+1];
        for (int s = 0; s < NUM_SLOTS; s++) begin
            src       = (s == 1) ? 2 : (s == 2) ? 1 : s;
            r.slot    = SLOT_W'(s);
            r.value   = data_bits[CH_W*src +: CH_W];
            r.link_up = link_ok;
            r.last    = (s == NUM_SLOTS - 1);
            expected_channels.push_back(r);
        end
        o_frames++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN; i++)
                rx_window[i] = 8'h00;
            bytes_since_frame = '0;
            missed_frames     = '0;
            link_ok           = 1'b1;
            lost_limit        = LIMIT_RST;
            expected_channels.delete();
        end else begin
            if (i_ch_valid && !i_ch_stall)
                check_channel();
            if (i_cfg_we)
                lost_limit = i_cfg_wdata;
            if (i_rx_valid && !i_rx_stall)
                take_byte(i_rx_byte);
        end
        o_pending = expected_channels.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the S.BUS frame decoder bench: clock, reset, byte stimulus, limit writes, verdict.
// Depends on sbus_pkg, sbus_frame_decoder_top and sbus_frame_checker.
module testbench;
    import sbus_pkg::*;

    localparam int DATA_LEN = WIN_LEN - 3;

    typedef enum logic [1:0] {PAY_RANDOM, PAY_ONES, PAY_ZEROS} t_payload;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              rx_valid;
    logic              rx_stall;
    logic [7:0]        rx_byte;
    logic              cfg_we;
    logic [LOST_W-1:0] cfg_wdata;
    logic              ch_valid;
    logic              ch_stall;
    logic [SLOT_W-1:0] slot;
    logic [CH_W-1:0]   value;
    logic              link_up;
    logic              last;
    logic              idle_en;
    int                bytes_sent;
    int                chk_fails;
    int                chk_pending;
    int                chk_frames;
    int                chk_results;

    always #1 clk = ~clk;

    sbus_frame_decoder_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_rx_valid  (rx_valid),
        .o_rx_stall  (rx_stall),
        .i_rx_byte   (rx_byte),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_ch_valid  (ch_valid),
        .i_ch_stall  (ch_stall),
        .o_slot      (slot),
        .o_value     (value),
        .o_link_up   (link_up),
        .o_last      (last)
    );

    sbus_frame_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (rx_valid),
        .i_rx_stall   (rx_stall),
        .i_rx_byte    (rx_byte),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_ch_valid   (ch_valid),
        .i_ch_stall   (ch_stall),
        .i_slot       (slot),
        .i_value      (value),
        .i_link_up    (link_up),
        .i_last       (last),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_frames     (chk_frames),
        .o_results    (chk_results)
    );

    // biased toward the framing and flag codes so that false frames get tried
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return SYNC_BYTE;
            1:       return END_BYTE;
            2:       return LOST_FLAGS;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_flags();
        if ($urandom_range(0, 9) < 4)
            return LOST_FLAGS;
        return 8'($urandom);
    endfunction

    // stall is checked at the falling edge, the transfer happens at the next rising edge
    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        forever begin
            @(negedge clk);
            if (!rx_stall)
                break;
        end
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] flags, input t_payload fill);
        send_byte(SYNC_BYTE);
        for (int i = 0; i < DATA_LEN; i++) begin
            case (fill)
                PAY_ONES:  send_byte(8'hFF);
                PAY_ZEROS: send_byte(8'h00);
                default:   send_byte(rand_byte());
            endcase
        end
        send_byte(flags);
        send_byte(END_BYTE);
    endtask

    // sync byte followed by a short run, or a full-length run with a bad end byte
    task automatic send_broken();
        int k;
        k = $urandom_range(1, WIN_LEN - 1);
        send_byte(SYNC_BYTE);
        repeat (k - 1) send_byte(rand_byte());
        if (k == WIN_LEN - 1)
            send_byte(8'h80 | rand_byte());
        else
            send_byte(rand_byte());
    endtask

    task automatic random_phase(input int n_bytes);
        int target;
        int pick;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_frame(rand_flags(), PAY_RANDOM);
            else if (pick < 8)
                send_broken();
            else
                repeat ($urandom_range(1, 6)) send_byte(rand_byte());
        end
    endtask

    task automatic drain();
        rx_valid <= 1'b0;
        do @(negedge clk); while (chk_pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LOST_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // output side stall bursts, cut short once idling is off
    initial begin
        int hold;
        hold     = 0;
        ch_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (!idle_en) begin
                hold = 0;
                ch_stall <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                ch_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 11);
                ch_stall <= 1'b1;
            end else begin
                ch_stall <= 1'b0;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        logic [LOST_W-1:0] lim;
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = 8'h00;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        idle_en    = 1'b0;
        bytes_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray bytes, all-ones payload with lost flags at the reset limit
        send_byte(END_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(8'hFF);
        send_frame(LOST_FLAGS, PAY_ONES);
        drain();
        // zero limit: a second lost frame takes the link down, any other flags bring it back
        write_limit(5'd0);
        send_frame(LOST_FLAGS, PAY_ZEROS);
        send_frame(8'hFF, PAY_RANDOM);
        drain();

        idle_en <= 1'b1;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0:       lim = 5'd1;
                1:       lim = 5'd30;
                default: lim = LOST_W'($urandom_range(2, 29));
            endcase
            write_limit(lim);
            random_phase(10);
            drain();
        end

        // no idling from here on; top limit keeps the link up
        idle_en <= 1'b0;
        write_limit(5'd31);
        send_frame(LOST_FLAGS, PAY_RANDOM);
        send_frame(8'h00, PAY_RANDOM);
        drain();
        repeat (20) @(posedge clk);

        $display("%0d bytes sent, %0d frames decoded, %0d channel results checked",
                 bytes_sent, chk_frames, chk_results);
        $display("limits 0, 1, 25, 30, 31 and one random; lost, clean and broken frames");
        if (chk_fails == 0 && chk_pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sbus_pkg.sv
rtl/sbus_emit.sv
rtl/sbus_frame_decoder_top.sv
tb/sv/sbus_frame_checker.sv
tb/sv/testbench.sv
